/* sv/lcabl_pkg.sv */
// lcabl_pkg: types, codes and microprogram for the binary lifting lca block
package lcabl_pkg;

  localparam int NODE_W        = 10;
  localparam int CMD_W         = 2;
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_depth_in;
  } in_req_t;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] ancestor;
  } out_req_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD_WR,
    OP_RD_DEP_U,
    OP_DU_RD_DEP_V,
    OP_DV_LD,
    OP_SWAP_DIFF,
    OP_LIFT_RD,
    OP_V_LD,
    OP_EQ_PREP,
    OP_RD_U_L,
    OP_AU_RD_V_L,
    OP_LVL_STEP,
    OP_RD_U_0,
    OP_RES_LD,
    OP_EMIT_QRY,
    OP_BUILD_INIT,
    OP_RD_I_JM1,
    OP_RD_P_JM1,
    OP_BUILD_WR,
    OP_EMIT_BLD
  } op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_DISPATCH,
    CND_DIFF_ZERO,
    CND_U_EQ_V,
    CND_LVL_NZ,
    CND_LAST_ZERO,
    CND_BUILD_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef logic [4:0] upc_t;

  localparam upc_t UPC_IDLE   = 5'd0;
  localparam upc_t UPC_LOAD   = 5'd1;
  localparam upc_t UPC_Q0     = 5'd2;
  localparam upc_t UPC_Q1     = 5'd3;
  localparam upc_t UPC_Q2     = 5'd4;
  localparam upc_t UPC_Q3     = 5'd5;
  localparam upc_t UPC_Q4     = 5'd6;
  localparam upc_t UPC_Q5     = 5'd7;
  localparam upc_t UPC_Q6     = 5'd8;
  localparam upc_t UPC_Q7     = 5'd9;
  localparam upc_t UPC_Q8     = 5'd10;
  localparam upc_t UPC_Q9     = 5'd11;
  localparam upc_t UPC_Q10    = 5'd12;
  localparam upc_t UPC_Q11    = 5'd13;
  localparam upc_t UPC_EMIT_Q = 5'd14;
  localparam upc_t UPC_B0     = 5'd15;
  localparam upc_t UPC_B1     = 5'd16;
  localparam upc_t UPC_B2     = 5'd17;
  localparam upc_t UPC_B3     = 5'd18;
  localparam upc_t UPC_EMIT_B = 5'd19;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jmp;
    upc_t  nxt;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic diff_zero;
    logic u_eq_v;
    logic lvl_nz;
    logic last_zero;
    logic build_more;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode_rom(input upc_t s);
    uword_t w;
    unique case (s)
      UPC_IDLE:   w = '{op: OP_NOP,         cond: CND_DISPATCH,   jmp: UPC_IDLE,   nxt: UPC_IDLE};
      UPC_LOAD:   w = '{op: OP_LOAD_WR,     cond: CND_ALWAYS,     jmp: UPC_IDLE,   nxt: UPC_IDLE};
      UPC_Q0:     w = '{op: OP_RD_DEP_U,    cond: CND_ALWAYS,     jmp: UPC_Q1,     nxt: UPC_Q1};
      UPC_Q1:     w = '{op: OP_DU_RD_DEP_V, cond: CND_ALWAYS,     jmp: UPC_Q2,     nxt: UPC_Q2};
      UPC_Q2:     w = '{op: OP_DV_LD,       cond: CND_ALWAYS,     jmp: UPC_Q3,     nxt: UPC_Q3};
      UPC_Q3:     w = '{op: OP_SWAP_DIFF,   cond: CND_ALWAYS,     jmp: UPC_Q4,     nxt: UPC_Q4};
      UPC_Q4:     w = '{op: OP_LIFT_RD,     cond: CND_DIFF_ZERO,  jmp: UPC_Q6,     nxt: UPC_Q5};
      UPC_Q5:     w = '{op: OP_V_LD,        cond: CND_ALWAYS,     jmp: UPC_Q4,     nxt: UPC_Q4};
      UPC_Q6:     w = '{op: OP_EQ_PREP,     cond: CND_U_EQ_V,     jmp: UPC_EMIT_Q, nxt: UPC_Q7};
      UPC_Q7:     w = '{op: OP_RD_U_L,      cond: CND_ALWAYS,     jmp: UPC_Q8,     nxt: UPC_Q8};
      UPC_Q8:     w = '{op: OP_AU_RD_V_L,   cond: CND_ALWAYS,     jmp: UPC_Q9,     nxt: UPC_Q9};
      UPC_Q9:     w = '{op: OP_LVL_STEP,    cond: CND_LVL_NZ,     jmp: UPC_Q7,     nxt: UPC_Q10};
      UPC_Q10:    w = '{op: OP_RD_U_0,      cond: CND_ALWAYS,     jmp: UPC_Q11,    nxt: UPC_Q11};
      UPC_Q11:    w = '{op: OP_RES_LD,      cond: CND_ALWAYS,     jmp: UPC_EMIT_Q, nxt: UPC_EMIT_Q};
      UPC_EMIT_Q: w = '{op: OP_EMIT_QRY,    cond: CND_OUT_BUSY,   jmp: UPC_EMIT_Q, nxt: UPC_IDLE};
      UPC_B0:     w = '{op: OP_BUILD_INIT,  cond: CND_LAST_ZERO,  jmp: UPC_EMIT_B, nxt: UPC_B1};
      UPC_B1:     w = '{op: OP_RD_I_JM1,    cond: CND_ALWAYS,     jmp: UPC_B2,     nxt: UPC_B2};
      UPC_B2:     w = '{op: OP_RD_P_JM1,    cond: CND_ALWAYS,     jmp: UPC_B3,     nxt: UPC_B3};
      UPC_B3:     w = '{op: OP_BUILD_WR,    cond: CND_BUILD_MORE, jmp: UPC_B1,     nxt: UPC_EMIT_B};
      UPC_EMIT_B: w = '{op: OP_EMIT_BLD,    cond: CND_OUT_BUSY,   jmp: UPC_EMIT_B, nxt: UPC_IDLE};
      default:    w = '{op: OP_NOP,         cond: CND_ALWAYS,     jmp: UPC_IDLE,   nxt: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/lca_binary_lifting.sv */
// lca_binary_lifting: top level of the microcoded binary lifting lca engine
// load request: writes one parent and depth; build: fills levels 1..LEVELS-1 of nodes 1..min(node_count, MAX_NODES-1)
// query: lifts (one per set bit of the depth difference), then walks levels LEVELS-1 down to 0
// one request at a time; the next is taken while the last result waits in the output register
// sync active-low reset clears the step counter, output valid and node_count (1023); no memory clear
module lca_binary_lifting #(
  parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lcabl_pkg::in_req_t           in_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lcabl_pkg::out_req_t          out_req,
  input  logic                         cfg_wr_en,
  input  logic [lcabl_pkg::NODE_W-1:0] cfg_wr_data
);

  lcabl_pkg::ctrl_t   ctrl;
  lcabl_pkg::status_t stat;

  lcabl_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_req.cmd),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  lcabl_datapath #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_req     (out_req),
    .stat        (stat)
  );

endmodule

/* sv/lcabl_useq.sv */
// lcabl_useq: step counter, microprogram lookup and jump logic
module lcabl_useq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [lcabl_pkg::CMD_W-1:0] in_cmd,
  input  lcabl_pkg::status_t        stat,
  output logic                      in_ready,
  output lcabl_pkg::ctrl_t          ctrl
);

  lcabl_pkg::upc_t   upc_r;
  lcabl_pkg::upc_t   upc_nxt;
  lcabl_pkg::uword_t uw;
  logic              taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lcabl_pkg::UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    uw       = lcabl_pkg::ucode_rom(upc_r);
    in_ready = (uw.cond == lcabl_pkg::CND_DISPATCH);
    taken    = 1'b0;
    unique case (uw.cond)
      lcabl_pkg::CND_ALWAYS:     taken = 1'b1;
      lcabl_pkg::CND_DISPATCH:   taken = 1'b0;
      lcabl_pkg::CND_DIFF_ZERO:  taken = stat.diff_zero;
      lcabl_pkg::CND_U_EQ_V:     taken = stat.u_eq_v;
      lcabl_pkg::CND_LVL_NZ:     taken = stat.lvl_nz;
      lcabl_pkg::CND_LAST_ZERO:  taken = stat.last_zero;
      lcabl_pkg::CND_BUILD_MORE: taken = stat.build_more;
      lcabl_pkg::CND_OUT_BUSY:   taken = stat.out_busy;
      default:                   taken = 1'b1;
    endcase
    upc_nxt = taken ? uw.jmp : uw.nxt;
    if (in_ready) begin
      upc_nxt = lcabl_pkg::UPC_IDLE;
      if (in_valid) begin
        unique case (lcabl_pkg::cmd_t'(in_cmd))
          lcabl_pkg::CMD_LOAD:  upc_nxt = lcabl_pkg::UPC_LOAD;
          lcabl_pkg::CMD_BUILD: upc_nxt = lcabl_pkg::UPC_B0;
          lcabl_pkg::CMD_QUERY: upc_nxt = lcabl_pkg::UPC_Q0;
          default:              upc_nxt = lcabl_pkg::UPC_IDLE;
        endcase
      end
    end
    ctrl.op   = uw.op;
    ctrl.take = in_valid && in_ready;
  end

endmodule

/* sv/lcabl_datapath.sv */
// lcabl_datapath: node registers, ancestor and depth memories, output register
module lcabl_datapath #(
  parameter int MAX_NODES = lcabl_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lcabl_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lcabl_pkg::ctrl_t             ctrl,
  input  lcabl_pkg::in_req_t           in_req,
  input  logic                         cfg_wr_en,
  input  logic [lcabl_pkg::NODE_W-1:0] cfg_wr_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output lcabl_pkg::out_req_t          out_req,
  output lcabl_pkg::status_t           stat
);

  localparam int NW        = lcabl_pkg::NODE_W;
  localparam int NIDX_W    = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ADDR_W    = NIDX_W + LVL_W;
  localparam int ANC_DEPTH = MAX_NODES * (1 << LVL_W);
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  logic [NW-1:0] anc_mem [ANC_DEPTH];
  logic [NW-1:0] dep_mem [MAX_NODES];

  logic [NW-1:0]    u_r, v_r, au_r, res_r, d_r;
  logic [NW-1:0]    du_r, dv_r, diff_r;
  logic [NW-1:0]    i_r, last_r, node_count_r;
  logic [LVL_W-1:0] lvl_r, j_r;
  logic [NW-1:0]    anc_rd_r, dep_rd_r;
  logic             anc_z_r, dep_z_r;
  logic             out_valid_r;
  lcabl_pkg::out_req_t out_r;

  logic [NW-1:0]     anc_q, dep_q;
  logic [NW-1:0]     rd_node, dep_node, last_c, step_c;
  logic [LVL_W-1:0]  rd_lvl, x_c;
  logic [3:0]        fl_c;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [NIDX_W-1:0] dep_addr, dep_wr_addr;
  logic [NW-1:0]     wr_data;
  logic              wr_en, dep_wr_en, out_busy;

  function automatic logic node_ok(input logic [NW-1:0] n);
    return (n != '0) && (32'(n) < MAX_NODES);
  endfunction

  assign anc_q    = anc_z_r ? '0 : anc_rd_r;
  assign dep_q    = dep_z_r ? '0 : dep_rd_r;
  assign out_busy = out_valid_r && !out_ready;
  assign last_c   = (32'(node_count_r) > MAX_NODES - 1) ? NW'(MAX_NODES - 1) : node_count_r;

  // largest lift step in the remaining depth difference
  always_comb begin
    fl_c = '0;
    for (int k = 0; k < NW; k++) begin
      if (diff_r[k]) begin
        fl_c = 4'(k);
      end
    end
    x_c    = (32'(fl_c) > LEVELS - 1) ? LVL_TOP : LVL_W'(fl_c);
    step_c = NW'(1) << x_c;
  end

  always_comb begin
    rd_node = u_r;
    rd_lvl  = '0;
    unique case (ctrl.op)
      lcabl_pkg::OP_LIFT_RD: begin
        rd_node = v_r;
        rd_lvl  = x_c;
      end
      lcabl_pkg::OP_RD_U_L: begin
        rd_node = u_r;
        rd_lvl  = lvl_r;
      end
      lcabl_pkg::OP_AU_RD_V_L: begin
        rd_node = v_r;
        rd_lvl  = lvl_r;
      end
      lcabl_pkg::OP_RD_I_JM1: begin
        rd_node = i_r;
        rd_lvl  = j_r - 1'b1;
      end
      lcabl_pkg::OP_RD_P_JM1: begin
        rd_node = anc_q;
        rd_lvl  = j_r - 1'b1;
      end
      default: begin
        rd_node = u_r;
        rd_lvl  = '0;
      end
    endcase
    rd_addr  = node_ok(rd_node) ? {NIDX_W'(rd_node), rd_lvl} : '0;
    dep_node = (ctrl.op == lcabl_pkg::OP_DU_RD_DEP_V) ? v_r : u_r;
    dep_addr = node_ok(dep_node) ? NIDX_W'(dep_node) : '0;

    wr_en       = 1'b0;
    wr_addr     = {NIDX_W'(u_r), LVL_W'(0)};
    wr_data     = v_r;
    dep_wr_en   = 1'b0;
    dep_wr_addr = NIDX_W'(u_r);
    if (ctrl.op == lcabl_pkg::OP_LOAD_WR) begin
      wr_en     = node_ok(u_r);
      dep_wr_en = node_ok(u_r);
    end else if (ctrl.op == lcabl_pkg::OP_BUILD_WR) begin
      wr_en   = 1'b1;
      wr_addr = {NIDX_W'(i_r), j_r};
      wr_data = anc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      anc_mem[wr_addr] <= wr_data;
    end
    if (dep_wr_en) begin
      dep_mem[dep_wr_addr] <= d_r;
    end
    anc_rd_r <= anc_mem[rd_addr];
    anc_z_r  <= !node_ok(rd_node);
    dep_rd_r <= dep_mem[dep_addr];
    dep_z_r  <= !node_ok(dep_node);
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      u_r <= in_req.node_a;
      v_r <= in_req.node_b;
      d_r <= in_req.node_depth_in;
    end
    unique case (ctrl.op)
      lcabl_pkg::OP_DU_RD_DEP_V: du_r <= dep_q;
      lcabl_pkg::OP_DV_LD:       dv_r <= dep_q;
      lcabl_pkg::OP_SWAP_DIFF: begin
        if (du_r > dv_r) begin
          u_r    <= v_r;
          v_r    <= u_r;
          diff_r <= du_r - dv_r;
        end else begin
          diff_r <= dv_r - du_r;
        end
      end
      lcabl_pkg::OP_LIFT_RD: begin
        if (diff_r != '0) begin
          diff_r <= diff_r - step_c;
        end
      end
      lcabl_pkg::OP_V_LD: v_r <= anc_q;
      lcabl_pkg::OP_EQ_PREP: begin
        res_r <= u_r;
        lvl_r <= LVL_TOP;
      end
      lcabl_pkg::OP_AU_RD_V_L: au_r <= anc_q;
      lcabl_pkg::OP_LVL_STEP: begin
        if (au_r != anc_q) begin
          u_r <= au_r;
          v_r <= anc_q;
        end
        lvl_r <= lvl_r - 1'b1;
      end
      lcabl_pkg::OP_RES_LD: res_r <= anc_q;
      lcabl_pkg::OP_BUILD_INIT: begin
        i_r    <= NW'(1);
        j_r    <= LVL_W'(1);
        last_r <= last_c;
      end
      lcabl_pkg::OP_BUILD_WR: begin
        if (i_r == last_r) begin
          i_r <= NW'(1);
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= lcabl_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (!out_busy && (ctrl.op == lcabl_pkg::OP_EMIT_QRY ||
                        ctrl.op == lcabl_pkg::OP_EMIT_BLD)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_busy) begin
      if (ctrl.op == lcabl_pkg::OP_EMIT_QRY) begin
        out_r.kind     <= lcabl_pkg::KIND_QUERY;
        out_r.ancestor <= res_r;
      end else if (ctrl.op == lcabl_pkg::OP_EMIT_BLD) begin
        out_r.kind     <= lcabl_pkg::KIND_BUILD;
        out_r.ancestor <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

  assign stat.diff_zero  = (diff_r == '0);
  assign stat.u_eq_v     = (u_r == v_r);
  assign stat.lvl_nz     = (lvl_r != '0);
  assign stat.last_zero  = (last_c == '0);
  assign stat.build_more = !((i_r == last_r) && (j_r == LVL_TOP));
  assign stat.out_busy   = out_busy;

endmodule

/* sim/lca_binary_lifting_tb.sv */
// self-checking testbench for the binary lifting lca engine with its own ancestor predictor
`timescale 1ns / 100ps

module lca_binary_lifting_tb;

  localparam int NODES         = lcabl_pkg::MAX_NODES_DEF;
  localparam int LVLS          = lcabl_pkg::LEVELS_DEF;
  localparam int DEPTH_MAX     = (1 << lcabl_pkg::NODE_W) - 1;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DIR_ROWS      = 25;

  typedef logic [lcabl_pkg::NODE_W-1:0] node_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_PIN
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    lcabl_pkg::cmd_t cmd;
    node_t           a;
    node_t           b;
    node_t           d;
    node_t           pin;
  } stim_row_t;

  // cfg rows carry node_count in a
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd0,    10'd0,    10'd0,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_NONE,  10'd1023, 10'd1023, 10'd1023, 10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd0,    10'd1023, 10'd1023, 10'd0},
    '{ROW_CFG,  lcabl_pkg::CMD_NONE,  10'd0,    10'd0,    10'd0,    10'd0},
    '{ROW_PIN,  lcabl_pkg::CMD_BUILD, 10'd0,    10'd0,    10'd0,    10'd0},
    '{ROW_CFG,  lcabl_pkg::CMD_NONE,  10'd1,    10'd0,    10'd0,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd1,    10'd0,    10'd1,    10'd0},
    '{ROW_PIN,  lcabl_pkg::CMD_BUILD, 10'd1023, 10'd1023, 10'd1023, 10'd0},
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd1,    10'd1,    10'd0,    10'd1},
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd1,    10'd0,    10'd0,    10'd0},
    '{ROW_CFG,  lcabl_pkg::CMD_NONE,  10'd7,    10'd0,    10'd0,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd2,    10'd1,    10'd2,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd3,    10'd1,    10'd2,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd4,    10'd2,    10'd3,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd5,    10'd2,    10'd3,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd6,    10'd3,    10'd3,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd7,    10'd4,    10'd4,    10'd0},
    '{ROW_PIN,  lcabl_pkg::CMD_BUILD, 10'd0,    10'd0,    10'd0,    10'd0},
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd7,    10'd5,    10'd0,    10'd2},
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd7,    10'd6,    10'd0,    10'd1},
    '{ROW_PIN,  lcabl_pkg::CMD_QUERY, 10'd4,    10'd7,    10'd0,    10'd4},
    '{ROW_PRED, lcabl_pkg::CMD_QUERY, 10'd6,    10'd5,    10'd1023, 10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_LOAD,  10'd5,    10'd7,    10'd1023, 10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_QUERY, 10'd5,    10'd1,    10'd0,    10'd0},
    '{ROW_PRED, lcabl_pkg::CMD_QUERY, 10'd3,    10'd5,    10'd0,    10'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lcabl_pkg::in_req_t  in_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lcabl_pkg::out_req_t out_req;
  logic                cfg_wr_en = 1'b0;
  node_t               cfg_wr_data = '0;

  node_t    lift_tbl [NODES][LVLS];
  node_t    depth_tbl [NODES];
  node_t    count_reg = lcabl_pkg::NODE_COUNT_RST;

  lcabl_pkg::out_req_t answer_q [$];
  int       mismatch_cnt = 0;
  int       work_cnt = 0;
  int       built_top = 0;
  int       stall_left = 0;
  bit       jitter_on = 1'b1;

  always #6 clk = ~clk;

  lca_binary_lifting DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_req    (out_req),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic node_t hop(input node_t node, input int lvl);
    if (node == '0 || int'(node) >= NODES || lvl >= LVLS) return '0;
    return lift_tbl[node][lvl];
  endfunction

  function automatic node_t depth_at(input node_t node);
    if (node == '0 || int'(node) >= NODES) return '0;
    return depth_tbl[node];
  endfunction

  function automatic int top_bit(input int x);
    int r;
    r = 0;
    while (x > 1) begin
      x = x >> 1;
      r++;
    end
    return r;
  endfunction

  function automatic node_t lowest_common(input node_t a, input node_t b);
    node_t u, v, t, au, av;
    int du, dv, gap, step, lvl;
    u = a;
    v = b;
    du = int'(depth_at(u));
    dv = int'(depth_at(v));
    if (du > dv) begin
      t = u;
      u = v;
      v = t;
      gap = du - dv;
    end else begin
      gap = dv - du;
    end
    while (gap > 0) begin
      step = top_bit(gap);
      if (step > LVLS - 1) step = LVLS - 1;
      v = hop(v, step);
      gap -= 1 << step;
    end
    if (u == v) return u;
    for (lvl = LVLS - 1; lvl >= 0; lvl--) begin
      au = hop(u, lvl);
      av = hop(v, lvl);
      if (au != av) begin
        u = au;
        v = av;
      end
    end
    return hop(u, 0);
  endfunction

  function automatic void rebuild_levels();
    int top, lvl, nd;
    node_t p;
    top = int'(count_reg);
    if (top > NODES - 1) top = NODES - 1;
    for (lvl = 1; lvl < LVLS; lvl++) begin
      for (nd = 1; nd <= top; nd++) begin
        p = lift_tbl[nd][lvl-1];
        lift_tbl[nd][lvl] = (p == '0) ? '0 : hop(p, lvl - 1);
      end
    end
  endfunction

  function automatic bit lca_predict(input lcabl_pkg::in_req_t r,
                                     output lcabl_pkg::out_req_t res);
    bit got;
    got = 1'b0;
    res = '0;
    case (r.cmd)
      lcabl_pkg::CMD_LOAD: begin
        if (r.node_a != '0 && int'(r.node_a) < NODES) begin
          lift_tbl[r.node_a][0] = r.node_b;
          depth_tbl[r.node_a] = r.node_depth_in;
        end
      end
      lcabl_pkg::CMD_BUILD: begin
        rebuild_levels();
        res.kind = lcabl_pkg::KIND_BUILD;
        got = 1'b1;
      end
      lcabl_pkg::CMD_QUERY: begin
        res.kind = lcabl_pkg::KIND_QUERY;
        res.ancestor = lowest_common(r.node_a, r.node_b);
        got = 1'b1;
      end
      default: got = 1'b0;
    endcase
    return got;
  endfunction

  function automatic lcabl_pkg::in_req_t make_req(input lcabl_pkg::cmd_t c, input int a,
                                                  input int b, input int d);
    lcabl_pkg::in_req_t r;
    r.cmd = c;
    r.node_a = a[lcabl_pkg::NODE_W-1:0];
    r.node_b = b[lcabl_pkg::NODE_W-1:0];
    r.node_depth_in = d[lcabl_pkg::NODE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : result_check
    lcabl_pkg::out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d anc %0d",
                                  out_req.kind, out_req.ancestor));
      end else begin
        want = answer_q.pop_front();
        if (out_req.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_req.kind, want.kind));
        if (out_req.ancestor !== want.ancestor)
          report_mismatch($sformatf("ancestor %0d, want %0d",
                                    out_req.ancestor, want.ancestor));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_request(input lcabl_pkg::in_req_t r, input bit pinned = 1'b0,
                             input lcabl_pkg::out_req_t pinned_res = '0);
    lcabl_pkg::out_req_t res;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    if (lca_predict(r, res)) answer_q.insert(answer_q.size(), pinned ? pinned_res : res);
    if (!(r.cmd == lcabl_pkg::CMD_NONE ||
          (r.cmd == lcabl_pkg::CMD_LOAD && r.node_a == '0))) work_cnt++;
  endtask

  task automatic set_node_count(input node_t v);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = v;
  endtask

  // noise that cannot reach an unwritten entry
  task automatic put_stray_request();
    case ($urandom_range(0, 2))
      0: put_request(make_req(lcabl_pkg::CMD_NONE, $urandom, $urandom, $urandom));
      1: put_request(make_req(lcabl_pkg::CMD_LOAD, 0, $urandom, $urandom));
      default: put_request(make_req(lcabl_pkg::CMD_QUERY, 0, 0, $urandom));
    endcase
  endtask

  task automatic grow_tree_phase(input int n, input bit deep);
    int i, par, dep, q, qn, span;
    set_node_count(n[lcabl_pkg::NODE_W-1:0]);
    for (i = 1; i <= n; i++) begin
      if ($urandom_range(0, 19) == 0) put_stray_request();
      if (i == 1 || $urandom_range(0, deep ? 255 : 15) == 0) par = 0;
      else if (deep && $urandom_range(0, 3) != 0) par = i - 1;
      else if (built_top > i && $urandom_range(0, 7) == 0) par = $urandom_range(1, built_top);
      else par = $urandom_range(1, i - 1);
      dep = (par == 0) ? 1 : int'(depth_tbl[par]) + 1;
      if (dep > DEPTH_MAX) dep = DEPTH_MAX;
      if ($urandom_range(0, 9) == 0) dep = $urandom_range(0, DEPTH_MAX);
      put_request(make_req(lcabl_pkg::CMD_LOAD, i, par, dep));
    end
    put_request(make_req(lcabl_pkg::CMD_BUILD, $urandom, $urandom, $urandom));
    if (n > built_top) built_top = n;
    qn = (n > 64) ? 80 : n + $urandom_range(4, 12);
    for (q = 0; q < qn; q++) begin
      case ($urandom_range(0, 15))
        0: put_request(make_req(lcabl_pkg::CMD_LOAD, $urandom_range(1, built_top),
                                $urandom_range(0, built_top), $urandom_range(0, DEPTH_MAX)));
        1: put_stray_request();
        default: begin
          span = ($urandom_range(0, 4) == 0) ? built_top : n;
          put_request(make_req(lcabl_pkg::CMD_QUERY, $urandom_range(0, span),
                               $urandom_range(0, span), $urandom));
        end
      endcase
    end
  endtask

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int k, n, pick;
    stim_row_t row;
    lcabl_pkg::out_req_t pin_res;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      row = DIRECTED[k];
      if (row.kind == ROW_CFG) begin
        set_node_count(row.a);
      end else begin
        pin_res.kind = (row.cmd == lcabl_pkg::CMD_QUERY) ? lcabl_pkg::KIND_QUERY
                                                         : lcabl_pkg::KIND_BUILD;
        pin_res.ancestor = row.pin;
        put_request(make_req(row.cmd, int'(row.a), int'(row.b), int'(row.d)),
                    row.kind == ROW_PIN, pin_res);
      end
    end

    work_cnt = 0;
    grow_tree_phase(int'(lcabl_pkg::NODE_COUNT_RST), 1'b1);
    while (work_cnt < RANDOM_ITEMS) begin
      jitter_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 1;
      else if (pick == 1) n = $urandom_range(60, 120);
      else n = $urandom_range(2, 32);
      grow_tree_phase(n, $urandom_range(0, 3) == 0);
    end

    // quiet tail with random idling turned off on both sides
    jitter_on = 1'b0;
    grow_tree_phase(1, 1'b0);
    grow_tree_phase($urandom_range(8, 24), 1'b1);
    in_valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* lca_binary_lifting.f */
sv/lcabl_pkg.sv
sv/lcabl_useq.sv
sv/lcabl_datapath.sv
sv/lca_binary_lifting.sv
sim/lca_binary_lifting_tb.sv
